FILE: hw/rtl/wrp_pkg.sv
package wrp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0]  EXP_CH_RESET   = 4'd2;
  localparam logic [31:0] EXP_RATE_RESET = 32'd48000;

  // magic words, first byte in the low lane
  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA    = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FMT_TAG_PCM  = 16'd1;
  localparam logic [15:0] BITS_16      = 16'd16;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_NO_DATA  = 3'd3;
  localparam logic [2:0] ST_NOT_PCM  = 3'd4;
  localparam logic [2:0] ST_CHANNELS = 3'd5;
  localparam logic [2:0] ST_RATE     = 3'd6;
  localparam logic [2:0] ST_BITS     = 3'd7;

  localparam logic CFG_IDX_CHANNELS = 1'b0;
  localparam logic CFG_IDX_RATE     = 1'b1;

  // one verdict as it travels from the parser to the divider
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [15:0] fmt_tag;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate_hz;
    logic [15:0] sample_bits;
    logic        size_warning;
    logic [3:0]  divisor;
  } wrp_result_t;

endpackage

FILE: hw/rtl/wrp_front.sv
module wrp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_file_byte,
  input  logic                in_last_byte,
  input  logic [3:0]          exp_channels,
  input  logic [31:0]         exp_rate_hz,
  input  logic                q_full,
  output logic                q_push,
  output wrp_pkg::wrp_result_t q_push_data
);
  import wrp_pkg::*;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_BODY = 5'b00100,
    PH_PAD  = 5'b01000,
    PH_STOP = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  logic [31:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [55:0] hdr_r, hdr_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  kind_t       kind_r, kind_nxt;
  logic        pad_r, pad_nxt;
  logic [4:0]  foff_r, foff_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] foffset_r, foffset_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        mbad_r, mbad_nxt;

  logic        accept;
  logic [31:0] hdr_id;
  logic [31:0] hdr_size;
  logic        mismatch;
  logic [2:0]  status;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign hdr_id   = hdr_r[31:0];
  assign hdr_size = {in_file_byte, hdr_r[55:32]};

  always_comb begin
    mismatch = 1'b0;
    if (hcnt_r < 4'd4) begin
      mismatch = in_file_byte != MAGIC_RIFF[hcnt_r[1:0]*8 +: 8];
    end else if (hcnt_r >= 4'd8) begin
      mismatch = in_file_byte != MAGIC_WAVE[hcnt_r[1:0]*8 +: 8];
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    hcnt_nxt    = hcnt_r;
    rem_nxt     = rem_r;
    kind_nxt    = kind_r;
    pad_nxt     = pad_r;
    foff_nxt    = foff_r;
    tag_nxt     = tag_r;
    chans_nxt   = chans_r;
    bits_nxt    = bits_r;
    rate_nxt    = rate_r;
    foffset_nxt = foffset_r;
    fsize_nxt   = fsize_r;
    err_nxt     = err_r;
    mbad_nxt    = mbad_r;
    status      = ST_OK;
    q_push      = 1'b0;

    if (accept) begin
      pos_nxt = pos_r + 32'd1;
      unique case (phase_r)
        PH_RIFF: begin
          mbad_nxt = mbad_r | mismatch;
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r == 4'd11) begin
            hcnt_nxt = 4'd0;
            if (mbad_nxt) begin
              err_nxt   = ST_MAGIC;
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          for (int i = 0; i < 7; i++) begin
            if (hcnt_r[2:0] == 3'(i)) begin
              hdr_nxt[i*8 +: 8] = in_file_byte;
            end
          end
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r == 4'd7) begin
            hdr_nxt  = '0;
            hcnt_nxt = 4'd0;
            rem_nxt  = hdr_size;
            pad_nxt  = hdr_size[0];
            foff_nxt = 5'd0;
            kind_nxt = KIND_OTHER;
            if (hdr_size != 32'd0) begin
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt = PH_HDR;
            end
            if (hdr_id == ID_FMT) begin
              if (hdr_size < FMT_MIN_SIZE) begin
                err_nxt   = ST_SIZE;
                phase_nxt = PH_STOP;
              end else begin
                kind_nxt = KIND_FMT;
              end
            end else if (hdr_id == ID_DATA) begin
              kind_nxt    = KIND_DATA;
              foffset_nxt = pos_r + 32'd1;
              fsize_nxt   = hdr_size;
            end
          end
        end
        PH_BODY: begin
          if (kind_r == KIND_FMT && foff_r < 5'd16) begin
            unique case (foff_r)
              5'd0:    tag_nxt[7:0]    = in_file_byte;
              5'd1:    tag_nxt[15:8]   = in_file_byte;
              5'd2:    chans_nxt[7:0]  = in_file_byte;
              5'd3:    chans_nxt[15:8] = in_file_byte;
              5'd4:    rate_nxt[7:0]   = in_file_byte;
              5'd5:    rate_nxt[15:8]  = in_file_byte;
              5'd6:    rate_nxt[23:16] = in_file_byte;
              5'd7:    rate_nxt[31:24] = in_file_byte;
              5'd14:   bits_nxt[7:0]   = in_file_byte;
              5'd15:   bits_nxt[15:8]  = in_file_byte;
              default: ;
            endcase
            foff_nxt = foff_r + 5'd1;
          end
          if (rem_r != 32'd0) begin
            rem_nxt = rem_r - 32'd1;
          end
          if (rem_nxt == 32'd0) begin
            phase_nxt = pad_r ? PH_PAD : PH_HDR;
          end
        end
        PH_PAD:  phase_nxt = PH_HDR;
        PH_STOP: ;
        default: ;
      endcase

      // verdict on the final word, from the state it leaves behind
      priority if (err_nxt != ST_OK)                          status = err_nxt;
      else if (phase_nxt == PH_RIFF)                          status = ST_SIZE;
      else if (phase_nxt == PH_BODY && rem_nxt != 32'd0)      status = ST_SIZE;
      else if (fsize_nxt == 32'd0)                            status = ST_NO_DATA;
      else if (tag_nxt != FMT_TAG_PCM)                        status = ST_NOT_PCM;
      else if (chans_nxt != {12'd0, exp_channels})            status = ST_CHANNELS;
      else if (rate_nxt != exp_rate_hz)                       status = ST_RATE;
      else if (bits_nxt != BITS_16)                           status = ST_BITS;
      else                                                    status = ST_OK;

      if (in_last_byte) begin
        q_push = 1'b1;
      end
    end
  end

  always_comb begin
    q_push_data.status       = status;
    q_push_data.data_offset  = foffset_nxt;
    q_push_data.data_size    = fsize_nxt;
    q_push_data.fmt_tag      = tag_nxt;
    q_push_data.fmt_channels = chans_nxt;
    q_push_data.fmt_rate_hz  = rate_nxt;
    q_push_data.sample_bits  = bits_nxt;
    q_push_data.size_warning = fsize_nxt[1:0] != 2'd0;
    q_push_data.divisor      = exp_channels;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      pos_r     <= '0;
      phase_r   <= PH_RIFF;
      hdr_r     <= '0;
      hcnt_r    <= '0;
      rem_r     <= '0;
      kind_r    <= KIND_OTHER;
      pad_r     <= 1'b0;
      foff_r    <= '0;
      tag_r     <= '0;
      chans_r   <= '0;
      bits_r    <= '0;
      rate_r    <= '0;
      foffset_r <= '0;
      fsize_r   <= '0;
      err_r     <= ST_OK;
      mbad_r    <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      hdr_r     <= hdr_nxt;
      hcnt_r    <= hcnt_nxt;
      rem_r     <= rem_nxt;
      kind_r    <= kind_nxt;
      pad_r     <= pad_nxt;
      foff_r    <= foff_nxt;
      tag_r     <= tag_nxt;
      chans_r   <= chans_nxt;
      bits_r    <= bits_nxt;
      rate_r    <= rate_nxt;
      foffset_r <= foffset_nxt;
      fsize_r   <= fsize_nxt;
      err_r     <= err_nxt;
      mbad_r    <= mbad_nxt;
    end
  end

endmodule

FILE: hw/rtl/wrp_queue.sv
module wrp_queue #(
  parameter int unsigned DEPTH = wrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wrp_pkg::wrp_result_t push_data,
  output logic                full,
  input  logic                pop,
  output wrp_pkg::wrp_result_t pop_data,
  output logic                empty
);
  import wrp_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wrp_result_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/wrp_back.sv
module wrp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  wrp_pkg::wrp_result_t q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [31:0]         out_data_offset,
  output logic [31:0]         out_data_size,
  output logic [30:0]         out_frames,
  output logic [15:0]         out_fmt_tag,
  output logic [15:0]         out_fmt_channels,
  output logic [31:0]         out_fmt_rate_hz,
  output logic [15:0]         out_sample_bits,
  output logic                out_size_warning
);
  import wrp_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_HOLD = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  wrp_result_t res_r, res_nxt;
  logic [30:0] dvd_r, dvd_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [4:0]  step_r, step_nxt;

  logic [4:0]  rem_sh;
  logic        qbit;

  // size / (2*ch) == (size >> 1) / ch, one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[30]};
  assign qbit   = rem_sh >= {1'b0, res_r.divisor};

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          res_nxt  = q_data;
          dvd_nxt  = q_data.data_size[31:1];
          rem_nxt  = 4'd0;
          step_nxt = 5'd0;
          if (q_data.divisor == 4'd0) begin
            dvd_nxt   = '0;
            state_nxt = BK_HOLD;
          end else begin
            state_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        rem_nxt  = qbit ? 4'(rem_sh - {1'b0, res_r.divisor}) : rem_sh[3:0];
        dvd_nxt  = {dvd_r[29:0], qbit};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd30) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign out_valid        = state_r == BK_HOLD;
  assign out_status       = res_r.status;
  assign out_data_offset  = res_r.data_offset;
  assign out_data_size    = res_r.data_size;
  assign out_frames       = dvd_r;
  assign out_fmt_tag      = res_r.fmt_tag;
  assign out_fmt_channels = res_r.fmt_channels;
  assign out_fmt_rate_hz  = res_r.fmt_rate_hz;
  assign out_sample_bits  = res_r.sample_bits;
  assign out_size_warning = res_r.size_warning;

endmodule

FILE: hw/rtl/wav_riff_header_parser.sv
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  file_byte[7:0], last_byte
// out       output     out_valid/out_ready status, offsets, fmt fields, frames
// cfg       input      apb psel/penable   expected_channels @0x0, expected_rate_hz @0x4
//
// one file byte is taken every cycle while the verdict queue has room
// with the back end idle a verdict leaves the queue after its last byte is taken,
// passes through the bit-serial frames divider and then shows on out_valid; with
// channels 0 it skips the divider
// reset is synchronous, active low: parse state and queue clear, the back end
// returns to idle, registers return to 2 channels and 48000 Hz
// out_ready low holds the verdict; later verdicts wait in the queue and
// in_ready drops only when the queue is full
module wav_riff_header_parser #(
  parameter int unsigned QUEUE_DEPTH = wrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size,
  output logic [30:0] out_frames,
  output logic [15:0] out_fmt_tag,
  output logic [15:0] out_fmt_channels,
  output logic [31:0] out_fmt_rate_hz,
  output logic [15:0] out_sample_bits,
  output logic        out_size_warning,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wrp_pkg::*;

  logic [3:0]  exp_ch_r;
  logic [31:0] exp_rate_r;
  logic        cfg_wr;

  wrp_result_t push_data;
  wrp_result_t pop_data;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r   <= EXP_CH_RESET;
      exp_rate_r <= EXP_RATE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_IDX_CHANNELS: exp_ch_r   <= pwdata[3:0];
        CFG_IDX_RATE:     exp_rate_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_CHANNELS: prdata = {28'd0, exp_ch_r};
      CFG_IDX_RATE:     prdata = exp_rate_r;
      default:          prdata = '0;
    endcase
  end

  wrp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_file_byte (in_file_byte),
    .in_last_byte (in_last_byte),
    .exp_channels (exp_ch_r),
    .exp_rate_hz  (exp_rate_r),
    .q_full       (full),
    .q_push       (push),
    .q_push_data  (push_data)
  );

  wrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  wrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (empty),
    .q_pop            (pop),
    .q_data           (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_data_offset  (out_data_offset),
    .out_data_size    (out_data_size),
    .out_frames       (out_frames),
    .out_fmt_tag      (out_fmt_tag),
    .out_fmt_channels (out_fmt_channels),
    .out_fmt_rate_hz  (out_fmt_rate_hz),
    .out_sample_bits  (out_sample_bits),
    .out_size_warning (out_size_warning)
  );

endmodule

FILE: test/wrp_verdict_monitor.sv
module wrp_verdict_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_data_offset,
  input  logic [31:0] out_data_size,
  input  logic [30:0] out_frames,
  input  logic [15:0] out_fmt_tag,
  input  logic [15:0] out_fmt_channels,
  input  logic [31:0] out_fmt_rate_hz,
  input  logic [15:0] out_sample_bits,
  input  logic        out_size_warning,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wrp_pkg::*;

  typedef enum logic [4:0] {
    WALK_MAGIC     = 5'b00001,
    WALK_CHUNK_HDR = 5'b00010,
    WALK_BODY      = 5'b00100,
    WALK_PAD       = 5'b01000,
    WALK_HALTED    = 5'b10000
  } walk_state_t;

  typedef enum logic [1:0] {
    BODY_OTHER = 2'd0,
    BODY_FMT   = 2'd1,
    BODY_DATA  = 2'd2
  } body_kind_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [30:0] frames;
    logic [15:0] fmt_tag;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate_hz;
    logic [15:0] sample_bits;
    logic        size_warning;
  } verdict_t;

  verdict_t verdicts_due[$];

  logic [3:0]  want_channels;
  logic [31:0] want_rate;

  logic [31:0] byte_pos;
  walk_state_t walk;
  logic [63:0] hdr_shift;
  logic [3:0]  hdr_cnt;
  logic [32:0] body_left;
  body_kind_t  body_kind;
  logic        pad_due;
  logic [4:0]  fmt_idx;
  logic [47:0] fmt_fields;   // tag, channels, bits per sample
  logic [31:0] fmt_rate;
  logic [31:0] data_off;
  logic [31:0] data_len;
  logic [2:0]  first_err;
  logic        magic_bad;
  int          errors = 0;

  task automatic clear_walk();
    byte_pos   = '0;
    walk       = WALK_MAGIC;
    hdr_shift  = '0;
    hdr_cnt    = '0;
    body_left  = '0;
    body_kind  = BODY_OTHER;
    pad_due    = 1'b0;
    fmt_idx    = '0;
    fmt_fields = '0;
    fmt_rate   = '0;
    data_off   = '0;
    data_len   = '0;
    first_err  = ST_OK;
    magic_bad  = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] id;
    logic [31:0] size;
    pos = byte_pos;
    byte_pos = byte_pos + 32'd1;
    case (walk)
      WALK_MAGIC: begin
        if (hdr_cnt < 4'd4 && b != MAGIC_RIFF[{hdr_cnt[1:0], 3'b000} +: 8])
          magic_bad = 1'b1;
        if (hdr_cnt >= 4'd8 && b != MAGIC_WAVE[{hdr_cnt[1:0], 3'b000} +: 8])
          magic_bad = 1'b1;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd12) begin
          hdr_cnt = '0;
          if (magic_bad) begin
            first_err = ST_MAGIC;
            walk = WALK_HALTED;
          end else begin
            walk = WALK_CHUNK_HDR;
          end
        end
      end
      WALK_CHUNK_HDR: begin
        hdr_shift[{hdr_cnt[2:0], 3'b000} +: 8] = b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd8) begin
          id = hdr_shift[31:0];
          size = hdr_shift[63:32];
          hdr_shift = '0;
          hdr_cnt = '0;
          body_left = {1'b0, size};
          pad_due = size[0];
          fmt_idx = '0;
          body_kind = BODY_OTHER;
          if (id == ID_FMT) begin
            if (size < FMT_MIN_SIZE) begin
              first_err = ST_SIZE;
              walk = WALK_HALTED;
            end else begin
              body_kind = BODY_FMT;
            end
          end else if (id == ID_DATA) begin
            body_kind = BODY_DATA;
            data_off = pos + 32'd1;
            data_len = size;
          end
          if (walk != WALK_HALTED) begin
            if (size != 0) walk = WALK_BODY;
            else walk = pad_due ? WALK_PAD : WALK_CHUNK_HDR;
          end
        end
      end
      WALK_BODY: begin
        if (body_kind == BODY_FMT && fmt_idx < 5'd16) begin
          if (fmt_idx < 5'd4)
            fmt_fields[{fmt_idx[1:0], 3'b000} +: 8] = b;
          else if (fmt_idx < 5'd8)
            fmt_rate[{fmt_idx[1:0], 3'b000} +: 8] = b;
          else if (fmt_idx >= 5'd14)
            fmt_fields[{fmt_idx - 5'd10, 3'b000} +: 8] = b;
          fmt_idx = fmt_idx + 5'd1;
        end
        if (body_left != 0) body_left = body_left - 33'd1;
        if (body_left == 0) walk = pad_due ? WALK_PAD : WALK_CHUNK_HDR;
      end
      WALK_PAD: walk = WALK_CHUNK_HDR;
      default: ;
    endcase
  endtask

  task automatic close_file();
    verdict_t v;
    logic [4:0]  divisor;
    logic [31:0] quotient;
    v.fmt_tag      = fmt_fields[15:0];
    v.fmt_channels = fmt_fields[31:16];
    v.sample_bits  = fmt_fields[47:32];
    v.fmt_rate_hz  = fmt_rate;
    v.data_offset  = data_off;
    v.data_size    = data_len;
    v.size_warning = (data_len[1:0] != 2'b00);
    if (first_err != ST_OK) v.status = first_err;
    else if (walk == WALK_MAGIC) v.status = ST_SIZE;
    else if (walk == WALK_BODY && body_left != 0) v.status = ST_SIZE;
    else if (data_len == 0) v.status = ST_NO_DATA;
    else if (v.fmt_tag != FMT_TAG_PCM) v.status = ST_NOT_PCM;
    else if (v.fmt_channels != {12'd0, want_channels}) v.status = ST_CHANNELS;
    else if (fmt_rate != want_rate) v.status = ST_RATE;
    else if (v.sample_bits != BITS_16) v.status = ST_BITS;
    else v.status = ST_OK;
    divisor = {want_channels, 1'b0};
    quotient = (divisor != 0) ? data_len / divisor : 32'd0;
    v.frames = quotient[30:0];
    verdicts_due.push_back(v);
    clear_walk();
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_verdict();
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      $display("%0t: verdict with none expected, status %0h", $time, out_status);
      errors++;
    end else begin
      v = verdicts_due.pop_front();
      check_field("status", 32'(v.status), 32'(out_status));
      check_field("data_offset", v.data_offset, out_data_offset);
      check_field("data_size", v.data_size, out_data_size);
      check_field("frames", 32'(v.frames), 32'(out_frames));
      check_field("fmt_tag", 32'(v.fmt_tag), 32'(out_fmt_tag));
      check_field("fmt_channels", 32'(v.fmt_channels), 32'(out_fmt_channels));
      check_field("fmt_rate_hz", v.fmt_rate_hz, out_fmt_rate_hz);
      check_field("sample_bits", 32'(v.sample_bits), 32'(out_sample_bits));
      check_field("size_warning", 32'(v.size_warning), 32'(out_size_warning));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_channels = EXP_CH_RESET;
      want_rate = EXP_RATE_RESET;
      clear_walk();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          CFG_IDX_CHANNELS: want_channels = pwdata[3:0];
          CFG_IDX_RATE:     want_rate = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_verdict();
      if (in_valid && in_ready) begin
        take_byte(in_file_byte);
        if (in_last_byte) close_file();
      end
    end
    fail_count <= errors;
    pending_count <= verdicts_due.size();
  end

endmodule

FILE: test/wav_riff_header_parser_test.sv
module wav_riff_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wrp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam logic [31:0] ID_LIST = 32'h5453_494C;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  out_status;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_size;
  logic [30:0] out_frames;
  logic [15:0] out_fmt_tag;
  logic [15:0] out_fmt_channels;
  logic [31:0] out_fmt_rate_hz;
  logic [15:0] out_sample_bits;
  logic        out_size_warning;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;

  logic [7:0]  file_buf[$];
  logic [3:0]  cur_channels = EXP_CH_RESET;
  logic [31:0] cur_rate = EXP_RATE_RESET;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int bytes_sent = 0;
  int quiet = 0;

  wav_riff_header_parser u_top (.*);

  wrp_verdict_monitor u_monitor (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  // watchdog on cycles with no word moving on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("wav_riff_header_parser_test: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
  endtask

  task automatic put_riff();
    put_le(MAGIC_RIFF, 4);
    put_le($urandom, 4);
    put_le(MAGIC_WAVE, 4);
  endtask

  task automatic put_fmt(input logic [31:0] size, input logic [15:0] tag,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits);
    put_le(ID_FMT, 4);
    put_le(size, 4);
    if (size < FMT_MIN_SIZE) begin
      put_rand(size);
    end else begin
      put_le(tag, 2);
      put_le(chans, 2);
      put_le(rate, 4);
      put_rand(6);   // byte rate and block align are not parsed
      put_le(bits, 2);
      put_rand(size - 16);
    end
    if (size[0]) put_rand(1);
  endtask

  task automatic put_good_fmt();
    put_fmt(16, FMT_TAG_PCM, {12'd0, cur_channels}, cur_rate, BITS_16);
  endtask

  // body shorter than size leaves the chunk running past the end
  task automatic put_data(input logic [31:0] size, input int body);
    put_le(ID_DATA, 4);
    put_le(size, 4);
    put_rand(body);
    if (body == size && size[0]) put_rand(1);
  endtask

  task automatic put_other(input logic [31:0] id, input int size);
    put_le(id, 4);
    put_le(size, 4);
    put_rand(size);
    if (size % 2 == 1) put_rand(1);
  endtask

  function automatic logic [31:0] mostly(input logic [31:0] usual);
    return ($urandom_range(99) < 85) ? usual : $urandom;
  endfunction

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin in_idle_pct = 0; out_stall_pct = 0; end
      1: begin in_idle_pct = 88; out_stall_pct = 0; end
      2: begin in_idle_pct = 0; out_stall_pct = 88; end
      default: begin in_idle_pct = 27; out_stall_pct = 27; end
    endcase
  endtask

  task automatic send_file();
    foreach (file_buf[i]) begin
      if ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
      end
      in_valid <= 1'b1;
      in_file_byte <= file_buf[i];
      in_last_byte <= (i == file_buf.size() - 1);
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
    end
    file_buf.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] chans, input logic [31:0] rate);
    wait_drained();
    // let the frame divider finish before touching the registers
    repeat (40) @(posedge clk);
    write_reg(CFG_IDX_CHANNELS, {28'd0, chans});
    write_reg(CFG_IDX_RATE, rate);
    cur_channels = chans;
    cur_rate = rate;
  endtask

  task automatic make_random_file();
    int pick;
    int chunks;
    logic [31:0] sz;
    pick = $urandom_range(99);
    if (pick < 8) begin
      put_rand($urandom_range(1, 24));
    end else begin
      put_riff();
      if (pick < 16) file_buf[$urandom_range(11)] ^= 8'($urandom_range(1, 255));
      chunks = $urandom_range(1, 4);
      for (int k = 0; k < chunks; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            case ($urandom_range(9))
              0: sz = $urandom_range(15);
              1: sz = $urandom_range(17, 20);
              default: sz = 16;
            endcase
            put_fmt(sz, mostly(FMT_TAG_PCM), mostly({28'd0, cur_channels}),
                    mostly(cur_rate), mostly(BITS_16));
          end
          4, 5, 6, 7: begin
            sz = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            put_data(sz, sz);
          end
          default: put_other($urandom, $urandom_range(5));
        endcase
      end
      case ($urandom_range(9))
        0: put_rand($urandom_range(1, 7));
        1: void'(file_buf.pop_back());
        2: put_data($urandom, $urandom_range(4));
        default: ;
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // good file at reset settings
    put_riff(); put_good_fmt(); put_data(8, 8); send_file();
    // too short to hold the magic
    put_le(MAGIC_RIFF, 1); send_file();
    put_le(MAGIC_RIFF, 4); put_rand(7); send_file();
    // magic only, no chunk
    put_riff(); send_file();
    set_phase(1);
    // bad riff word, rest of the file ignored
    put_riff(); file_buf[1] = 8'h58; put_good_fmt(); put_data(4, 4); send_file();
    // bad wave word
    put_le(MAGIC_RIFF, 4); put_rand(4); put_le(MAGIC_WAVE ^ 32'h0100_0000, 4);
    put_good_fmt(); put_data(4, 4); send_file();
    // short fmt chunk stops the walk
    put_riff(); put_fmt(14, FMT_TAG_PCM, 2, 48000, BITS_16);
    put_good_fmt(); put_data(4, 4); send_file();
    set_phase(2);
    put_riff(); put_fmt(16, 16'd3, 2, 48000, BITS_16); put_data(4, 4); send_file();
    put_riff(); put_fmt(16, FMT_TAG_PCM, 1, 48000, BITS_16); put_data(4, 4); send_file();
    put_riff(); put_fmt(16, FMT_TAG_PCM, 2, 44100, BITS_16); put_data(4, 4); send_file();
    put_riff(); put_fmt(16, FMT_TAG_PCM, 2, 48000, 16'd24); put_data(4, 4); send_file();
    set_phase(3);
    // long fmt, odd data with pad, odd list chunk, short trailing bytes
    put_riff(); put_fmt(18, FMT_TAG_PCM, 2, 48000, BITS_16); put_data(5, 5);
    put_other(ID_LIST, 3); put_rand(5); send_file();
    // final pad byte missing
    put_riff(); put_good_fmt(); put_data(7, 7); void'(file_buf.pop_back()); send_file();
    // last fmt and last data win
    put_riff(); put_fmt(16, 16'd3, 2, 48000, BITS_16); put_data(4, 4);
    put_good_fmt(); put_data(0, 0); send_file();
    put_riff(); put_good_fmt(); put_data(6, 6); put_data(12, 12); send_file();
    set_phase(0);
    // data chunk running past the end
    put_riff(); put_good_fmt(); put_data(32'hFFFF_FFFF, 3); send_file();
    put_riff(); put_fmt(16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_data(4, 4); send_file();
    // fmt body cut short
    put_riff(); put_le(ID_FMT, 4); put_le(16, 4); put_rand(6); send_file();
    put_riff(); put_other($urandom, 0); put_good_fmt(); put_data(0, 0); put_rand(3);
    send_file();

    // zero channels gives no frames
    write_config(4'd0, 32'hFFFF_FFFF);
    put_riff(); put_good_fmt(); put_data(8, 8); send_file();
    write_config(4'd15, 32'd1);
    put_riff(); put_good_fmt(); put_data(60, 60); send_file();
    write_config(4'd8, 32'd0);
    put_riff(); put_good_fmt(); put_data(33, 33); send_file();
    put_riff(); put_good_fmt(); put_data(32'hFFFF_FFFE, 2); send_file();

    for (int round = 0; bytes_sent < 1150 || round < 4; round++) begin
      case ($urandom_range(4))
        0: cur_channels = 4'd0;
        1: cur_channels = 4'd1;
        2: cur_channels = 4'd8;
        3: cur_channels = 4'd15;
        default: cur_channels = 4'($urandom_range(1, 8));
      endcase
      case ($urandom_range(4))
        0: cur_rate = 32'd1;
        1: cur_rate = 32'hFFFF_FFFF;
        2: cur_rate = 32'd48000;
        3: cur_rate = 32'd44100;
        default: cur_rate = $urandom;
      endcase
      write_config(cur_channels, cur_rate);
      set_phase(round);
      make_random_file();
      send_file();
      // hold off new words until every verdict is out
      if (round % 3 == 1) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("wav_riff_header_parser_test: done, clean");
    end else begin
      $display("wav_riff_header_parser_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: wav_riff_header_parser.f
hw/rtl/wrp_pkg.sv
hw/rtl/wrp_front.sv
hw/rtl/wrp_queue.sv
hw/rtl/wrp_back.sv
hw/rtl/wav_riff_header_parser.sv
test/wrp_verdict_monitor.sv
test/wav_riff_header_parser_test.sv
